@@ hw/rtl/rgba_histogram_statistics_assert.svh @@
// Assertion macros used by the histogram block checker.
`ifndef RGBA_HISTOGRAM_STATISTICS_ASSERT_SVH
`define RGBA_HISTOGRAM_STATISTICS_ASSERT_SVH

// Clocked assertion, disabled while reset is active.
`define RHS_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RHS_ASSERT_ANY(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/rgbahs_pkg.sv @@
// Shared codes, field layout and widths for the RGBA histogram block.
package rgbahs_pkg;

    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_PIXEL = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam int CH_W   = 3;
    localparam int NUM_CH = 5;
    localparam logic [CH_W-1:0] CH_VALUE = 3'd0;
    localparam logic [CH_W-1:0] CH_RED   = 3'd1;
    localparam logic [CH_W-1:0] CH_GREEN = 3'd2;
    localparam logic [CH_W-1:0] CH_BLUE  = 3'd3;
    localparam logic [CH_W-1:0] CH_ALPHA = 3'd4;

    localparam int SAMPLE_W = 16;
    localparam int FIELD_W  = 32;
    localparam int FX_W     = 24;

    localparam int IN_TDATA_W  = 104;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 168;
    localparam int OUT_TUSER_W = 1;

    localparam int IN_BLUE_LSB  = 0;
    localparam int IN_GREEN_LSB = 16;
    localparam int IN_RED_LSB   = 32;
    localparam int IN_ALPHA_LSB = 48;
    localparam int IN_CH_LSB    = 64;
    localparam int IN_FIRST_LSB = 67;
    localparam int IN_LAST_LSB  = 83;

    localparam int OUT_COUNT_LSB  = 0;
    localparam int OUT_MEAN_LSB   = 32;
    localparam int OUT_MEDIAN_LSB = 56;
    localparam int OUT_FOUND_BIT  = 72;
    localparam int OUT_SD_LSB     = 73;
    localparam int OUT_PEAK_LSB   = 97;
    localparam int OUT_TOTAL_LSB  = 129;

endpackage

@@ hw/rtl/rgba_histogram_statistics.sv @@
// RGBA histogram store with range statistics, top level.
// Pixel op: one transfer per cycle while idle; counts are written back in the following cycle (read, bump, write back).
// Clear op: sweeps all five bin memories to zero, input stalled.
// Query: walk over bins in use, V_W steps to divide for the mean, walk over the range,
//   V_W for the variance, T_W root steps; the walks are set by the one memory read port.
// Reset: async, active low; after release the same clearing sweep runs before any transfer.
module rgba_histogram_statistics #(
    parameter int BIN_BITS   = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // blue_sample, green_sample, red_sample, alpha_sample, channel_sel,
    // range_first, range_last (lowest bit up), zero pad
    input  logic [rgbahs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // op
    input  logic [rgbahs_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // range_count, mean_fx, median_bin, median_found, stddev_fx, peak_count,
    // pixel_total (lowest bit up), zero pad
    output logic [rgbahs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [rgbahs_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_wr_data
);
    import rgbahs_pkg::*;

    localparam int DEPTH = 1 << BIN_BITS;
    localparam int C_W   = COUNT_BITS + BIN_BITS;   // range sum
    localparam int PA_W  = BIN_BITS + COUNT_BITS;   // bin index times count
    localparam int S_W   = C_W + BIN_BITS;          // weighted sum
    localparam int T_W   = BIN_BITS + 8;            // fixed-point distance to mean
    localparam int TT_W  = 2 * T_W;
    localparam int PP_W  = T_W + COUNT_BITS;
    localparam int V_W   = TT_W + C_W;              // squared-deviation sum
    localparam int R_W   = C_W + 1;
    localparam int DC_W  = $clog2(V_W + 1);
    localparam int SC_W  = $clog2(T_W + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // state codes
    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_PASS_A   = 3'd2;  // peak over bins in use, sums over range
    localparam logic [2:0] ST_DIV_MEAN = 3'd3;
    localparam logic [2:0] ST_PASS_B   = 3'd4;  // median and squared deviations
    localparam logic [2:0] ST_DIV_VAR  = 3'd5;
    localparam logic [2:0] ST_SQRT     = 3'd6;
    localparam logic [2:0] ST_FINISH   = 3'd7;

    function automatic logic [BIN_BITS-1:0] bin_of(input logic [SAMPLE_W-1:0] smp,
                                                   input logic wide);
        return wide ? smp[BIN_BITS-1:0] : BIN_BITS'(smp[7:0]);
    endfunction

    // ---------------- control registers ----------------
    logic [2:0]            state_reg, state_next;
    logic [BIN_BITS-1:0]   clr_idx_reg;
    logic                  px1_valid_reg;   // pixel in read-modify-write stage
    logic                  fwd_valid_reg;   // a pixel write landed last edge
    logic                  issue_reg;       // walk still issuing reads
    logic [4:0]            v_reg;           // walk pipeline valids
    logic [DC_W-1:0]       div_cnt_reg;
    logic [SC_W-1:0]       sq_cnt_reg;
    logic                  out_valid_reg;
    logic                  wide_reg;
    logic [COUNT_BITS-1:0] pixels_reg;

    // ---------------- datapath registers ----------------
    logic [BIN_BITS-1:0]   px1_addr_reg [NUM_CH];
    logic [BIN_BITS-1:0]   fwd_addr_reg [NUM_CH];
    logic [COUNT_BITS-1:0] fwd_data_reg [NUM_CH];
    logic [CH_W-1:0]       ch_reg;
    logic [BIN_BITS-1:0]   first_reg, last_reg;
    logic                  bad_reg;
    logic [BIN_BITS-1:0]   walk_idx_reg, walk_end_reg, idx1_reg;
    logic [C_W-1:0]        c_reg, run_reg;
    logic [S_W-1:0]        s_reg;
    logic [PA_W-1:0]       prod_reg;
    logic [COUNT_BITS-1:0] peak_reg;
    logic                  found_reg;
    logic [BIN_BITS-1:0]   med_reg;
    logic [T_W-1:0]        mean_reg, sd_reg, t_reg;
    logic [COUNT_BITS-1:0] hb_reg, h3_reg;
    logic [TT_W-1:0]       tt_reg;
    logic [PP_W-1:0]       pplo_reg, pphi_reg;
    logic [V_W-1:0]        prodw_reg, acc_reg;
    logic [V_W-1:0]        dvd_reg;
    logic [C_W-1:0]        rem_reg;
    logic [TT_W-1:0]       q_reg;
    logic [TT_W-1:0]       x_reg, res_reg, bit_reg;
    logic [OUT_TDATA_W-1:0] out_tdata_reg;
    logic [OUT_TUSER_W-1:0] out_tuser_reg;

    // ---------------- input decode ----------------
    logic [OP_W-1:0]     op_in;
    logic [CH_W-1:0]     ch_in;
    logic [SAMPLE_W-1:0] first_in, last_in;
    logic                in_fire, is_pixel, is_query, is_clear, bad_query;
    logic [BIN_BITS-1:0] bin_mask;
    logic [BIN_BITS-1:0] pix_b, pix_g, pix_r, pix_a, max_bg, pix_max;
    logic [BIN_BITS-1:0] pix_addr [NUM_CH];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign op_in    = s_axis_tuser[OP_W-1:0];
    assign ch_in    = s_axis_tdata[IN_CH_LSB +: CH_W];
    assign first_in = s_axis_tdata[IN_FIRST_LSB +: SAMPLE_W];
    assign last_in  = s_axis_tdata[IN_LAST_LSB +: SAMPLE_W];
    assign is_pixel = in_fire && (op_in == OP_PIXEL);
    assign is_query = in_fire && (op_in == OP_QUERY);
    assign is_clear = in_fire && (op_in == OP_CLEAR);
    assign bin_mask = wide_reg ? {BIN_BITS{1'b1}} : BIN_BITS'(8'hFF);
    assign bad_query = (ch_in > CH_ALPHA) || (first_in > last_in)
                    || (last_in > SAMPLE_W'(bin_mask));

    assign pix_b   = bin_of(s_axis_tdata[IN_BLUE_LSB +: SAMPLE_W], wide_reg);
    assign pix_g   = bin_of(s_axis_tdata[IN_GREEN_LSB +: SAMPLE_W], wide_reg);
    assign pix_r   = bin_of(s_axis_tdata[IN_RED_LSB +: SAMPLE_W], wide_reg);
    assign pix_a   = bin_of(s_axis_tdata[IN_ALPHA_LSB +: SAMPLE_W], wide_reg);
    assign max_bg  = (pix_b > pix_g) ? pix_b : pix_g;
    assign pix_max = (pix_r > max_bg) ? pix_r : max_bg;

    assign pix_addr[CH_VALUE] = pix_max;
    assign pix_addr[CH_RED]   = pix_r;
    assign pix_addr[CH_GREEN] = pix_g;
    assign pix_addr[CH_BLUE]  = pix_b;
    assign pix_addr[CH_ALPHA] = pix_a;

    // ---------------- bin memories ----------------
    // Each channel owns one memory. In idle the read port follows the incoming
    // pixel; otherwise it follows the walk index. Read data is registered and ready in the
    // following cycle, when the bumped count is written back. A pixel read that raced the previous
    // write to the same bin takes the forwarded count instead. The first walk read
    // can race the write of a pixel taken just before the query; it is forwarded too.
    logic [COUNT_BITS-1:0] rd_data  [NUM_CH];
    logic [COUNT_BITS-1:0] cnt_next [NUM_CH];

    for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
        logic [COUNT_BITS-1:0] bins_mem [DEPTH];
        logic [COUNT_BITS-1:0] rd_q, cur_cnt, wdata;
        logic [BIN_BITS-1:0]   raddr, waddr;
        logic                  we;

        assign cur_cnt = (fwd_valid_reg && (fwd_addr_reg[c] == px1_addr_reg[c]))
                       ? fwd_data_reg[c] : rd_q;
        assign cnt_next[c] = (cur_cnt == CNT_MAX) ? cur_cnt
                                                  : cur_cnt + COUNT_BITS'(1);
        assign rd_data[c] = (fwd_valid_reg && (fwd_addr_reg[c] == idx1_reg))
                          ? fwd_data_reg[c] : rd_q;
        assign raddr = (state_reg == ST_IDLE) ? pix_addr[c] : walk_idx_reg;

        always_comb
        begin
            we    = 1'b0;
            waddr = px1_addr_reg[c];
            wdata = cnt_next[c];
            if (px1_valid_reg)
            begin
                we = 1'b1;
            end
            else if (state_reg == ST_CLEAR)
            begin
                we    = 1'b1;
                waddr = clr_idx_reg;
                wdata = '0;
            end
        end

        always_ff @(posedge clk)
        begin
            if (we)
            begin
                bins_mem[waddr] <= wdata;
            end
            rd_q <= bins_mem[raddr];
        end
    end

    // ---------------- query helpers ----------------
    logic [COUNT_BITS-1:0] h_sel;
    logic                  walk_done, div_last, sq_last, clr_last, out_free, in_range;
    logic [C_W-1:0]        run_next;
    logic [T_W-1:0]        pos_fx;
    logic [R_W-1:0]        r_sh;
    logic                  div_ge;
    logic [C_W-1:0]        rem_step;
    logic [TT_W-1:0]       q_step;
    logic [TT_W:0]         rb;
    logic                  sq_ge;
    logic [TT_W-1:0]       res_step;
    logic [FIELD_W-1:0]    count_sat;

    always_comb
    begin
        unique case (ch_reg)
            CH_VALUE: h_sel = rd_data[CH_VALUE];
            CH_RED:   h_sel = rd_data[CH_RED];
            CH_GREEN: h_sel = rd_data[CH_GREEN];
            CH_BLUE:  h_sel = rd_data[CH_BLUE];
            CH_ALPHA: h_sel = rd_data[CH_ALPHA];
            default:  h_sel = '0;
        endcase
    end

    assign walk_done = !issue_reg && (v_reg == '0);
    assign div_last  = (div_cnt_reg == DC_W'(V_W - 1));
    assign sq_last   = (sq_cnt_reg == SC_W'(T_W - 1));
    assign clr_last  = (clr_idx_reg == {BIN_BITS{1'b1}}) && !px1_valid_reg;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign in_range  = (idx1_reg >= first_reg) && (idx1_reg <= last_reg);
    assign run_next  = run_reg + C_W'(h_sel);
    assign pos_fx    = {idx1_reg, 8'h00};

    // restoring divide step, one quotient bit per cycle
    assign r_sh     = {rem_reg, dvd_reg[V_W-1]};
    assign div_ge   = (r_sh >= {1'b0, c_reg});
    assign rem_step = div_ge ? C_W'(r_sh - {1'b0, c_reg}) : r_sh[C_W-1:0];
    assign q_step   = {q_reg[TT_W-2:0], div_ge};

    // integer square root step, two radicand bits per cycle
    assign rb       = {1'b0, res_reg} + {1'b0, bit_reg};
    assign sq_ge    = ({1'b0, x_reg} >= rb);
    assign res_step = sq_ge ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);

    assign count_sat = (64'(c_reg) > 64'hFFFF_FFFF) ? {FIELD_W{1'b1}} : FIELD_W'(c_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:    if (clr_last) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (is_clear)
                begin
                    state_next = ST_CLEAR;
                end
                else if (is_query)
                begin
                    state_next = bad_query ? ST_FINISH : ST_PASS_A;
                end
            end
            ST_PASS_A:
            begin
                if (walk_done)
                begin
                    state_next = (c_reg != '0) ? ST_DIV_MEAN : ST_FINISH;
                end
            end
            ST_DIV_MEAN: if (div_last) state_next = ST_PASS_B;
            ST_PASS_B:   if (walk_done) state_next = ST_DIV_VAR;
            ST_DIV_VAR:  if (div_last) state_next = ST_SQRT;
            ST_SQRT:     if (sq_last) state_next = ST_FINISH;
            ST_FINISH:   if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // ---------------- control ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            px1_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            issue_reg     <= 1'b0;
            v_reg         <= '0;
            div_cnt_reg   <= '0;
            sq_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
            wide_reg      <= 1'b0;
            pixels_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            px1_valid_reg <= is_pixel;
            fwd_valid_reg <= px1_valid_reg;
            v_reg         <= {v_reg[3:0], issue_reg};
            div_cnt_reg   <= div_cnt_reg + DC_W'(1);
            sq_cnt_reg    <= sq_cnt_reg + SC_W'(1);

            if (cfg_wr_en)
            begin
                wide_reg <= cfg_wr_data;
            end

            if (is_clear)
            begin
                pixels_reg <= '0;
            end
            else if (is_pixel && (pixels_reg != CNT_MAX))
            begin
                pixels_reg <= pixels_reg + COUNT_BITS'(1);
            end

            if ((state_reg == ST_CLEAR) && !px1_valid_reg)
            begin
                clr_idx_reg <= clr_idx_reg + BIN_BITS'(1);
            end
            if (is_clear)
            begin
                clr_idx_reg <= '0;
            end

            if (issue_reg && (walk_idx_reg == walk_end_reg))
            begin
                issue_reg <= 1'b0;
            end
            if ((is_query && !bad_query) || ((state_reg == ST_DIV_MEAN) && div_last))
            begin
                issue_reg <= 1'b1;
            end

            if (((state_reg == ST_PASS_A) || (state_reg == ST_PASS_B)) && walk_done)
            begin
                div_cnt_reg <= '0;
            end
            if ((state_reg == ST_DIV_VAR) && div_last)
            begin
                sq_cnt_reg <= '0;
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            px1_addr_reg[c] <= pix_addr[c];
            fwd_addr_reg[c] <= px1_addr_reg[c];
            fwd_data_reg[c] <= cnt_next[c];
        end

        idx1_reg <= walk_idx_reg;
        if (issue_reg)
        begin
            walk_idx_reg <= walk_idx_reg + BIN_BITS'(1);
        end

        if (is_query)
        begin
            ch_reg       <= ch_in;
            first_reg    <= first_in[BIN_BITS-1:0];
            last_reg     <= last_in[BIN_BITS-1:0];
            bad_reg      <= bad_query;
            walk_idx_reg <= '0;
            walk_end_reg <= bin_mask;
            c_reg        <= '0;
            s_reg        <= '0;
            peak_reg     <= '0;
            run_reg      <= '0;
            acc_reg      <= '0;
            found_reg    <= 1'b0;
            med_reg      <= '0;
            mean_reg     <= '0;
            sd_reg       <= '0;
        end

        // pass A: peak over all bins in use, count and weighted sum over the range
        prod_reg <= in_range ? PA_W'(idx1_reg) * PA_W'(h_sel) : '0;
        if ((state_reg == ST_PASS_A) && v_reg[0])
        begin
            if (h_sel > peak_reg)
            begin
                peak_reg <= h_sel;
            end
            if (in_range)
            begin
                c_reg <= c_reg + C_W'(h_sel);
            end
        end
        if ((state_reg == ST_PASS_A) && v_reg[1])
        begin
            s_reg <= s_reg + S_W'(prod_reg);
        end

        // pass B: median, then h * (256*i - mean)^2 through four stages
        t_reg     <= (pos_fx >= mean_reg) ? (pos_fx - mean_reg) : (mean_reg - pos_fx);
        hb_reg    <= h_sel;
        tt_reg    <= TT_W'(t_reg) * TT_W'(t_reg);
        h3_reg    <= hb_reg;
        pplo_reg  <= PP_W'(tt_reg[T_W-1:0]) * PP_W'(h3_reg);
        pphi_reg  <= PP_W'(tt_reg[TT_W-1:T_W]) * PP_W'(h3_reg);
        prodw_reg <= V_W'(pplo_reg) + (V_W'(pphi_reg) << T_W);
        if ((state_reg == ST_PASS_B) && v_reg[0])
        begin
            run_reg <= run_next;
            if (!found_reg && ({run_next, 1'b0} > {1'b0, c_reg}))
            begin
                found_reg <= 1'b1;
                med_reg   <= idx1_reg;
            end
        end
        if ((state_reg == ST_PASS_B) && v_reg[4])
        begin
            acc_reg <= acc_reg + prodw_reg;
        end

        // shared divider
        if ((state_reg == ST_DIV_MEAN) || (state_reg == ST_DIV_VAR))
        begin
            dvd_reg <= {dvd_reg[V_W-2:0], 1'b0};
            rem_reg <= rem_step;
            q_reg   <= q_step;
        end
        if ((state_reg == ST_PASS_A) && walk_done)
        begin
            dvd_reg <= V_W'({s_reg, 8'h00});
            rem_reg <= '0;
            q_reg   <= '0;
        end
        if ((state_reg == ST_PASS_B) && walk_done)
        begin
            dvd_reg <= acc_reg;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        if ((state_reg == ST_DIV_MEAN) && div_last)
        begin
            mean_reg     <= q_step[T_W-1:0];
            walk_idx_reg <= first_reg;
            walk_end_reg <= last_reg;
        end

        // square root of the variance quotient
        if ((state_reg == ST_DIV_VAR) && div_last)
        begin
            x_reg   <= q_step;
            res_reg <= '0;
            bit_reg <= TT_W'(1) << (TT_W - 2);
        end
        if (state_reg == ST_SQRT)
        begin
            if (sq_ge)
            begin
                x_reg <= x_reg - rb[TT_W-1:0];
            end
            res_reg <= res_step;
            bit_reg <= bit_reg >> 2;
            if (sq_last)
            begin
                sd_reg <= res_step[T_W-1:0];
            end
        end

        // result register
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_tdata_reg <= '0;
            out_tuser_reg <= OUT_TUSER_W'(bad_reg);
            if (!bad_reg)
            begin
                out_tdata_reg[OUT_COUNT_LSB +: FIELD_W]  <= count_sat;
                out_tdata_reg[OUT_MEAN_LSB +: FX_W]      <= FX_W'(mean_reg);
                out_tdata_reg[OUT_MEDIAN_LSB +: SAMPLE_W] <= SAMPLE_W'(med_reg);
                out_tdata_reg[OUT_FOUND_BIT]             <= found_reg;
                out_tdata_reg[OUT_SD_LSB +: FX_W]        <= FX_W'(sd_reg);
                out_tdata_reg[OUT_PEAK_LSB +: FIELD_W]   <= FIELD_W'(peak_reg);
                out_tdata_reg[OUT_TOTAL_LSB +: FIELD_W]  <= FIELD_W'(pixels_reg);
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_tdata_reg;
    assign m_axis_tuser  = out_tuser_reg;

endmodule

@@ hw/rtl/rgbahs_checker.sv @@
// Port-level assertions for the RGBA histogram block, with its bind.
`include "rgba_histogram_statistics_assert.svh"

module rgbahs_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [rgbahs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [rgbahs_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [rgbahs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [rgbahs_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    input logic                               cfg_wr_en,
    input logic                               cfg_wr_data
);
    import rgbahs_pkg::*;

    logic unused_ok;
    assign unused_ok = ^{s_axis_tdata, cfg_wr_en, cfg_wr_data};

    // a query or clear takes the block busy on the next cycle
    `RHS_ASSERT_RST(a_busy_after_op, clk, rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_QUERY || s_axis_tuser == OP_CLEAR) |=> !s_axis_tready, "input ready right after a query or clear")

    // invalid query carries an all-zero payload
    `RHS_ASSERT_RST(a_bad_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0, "invalid-status result with nonzero fields")

    // no median only for an empty range, which zeros the statistics
    `RHS_ASSERT_RST(a_empty_range, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0] && !m_axis_tdata[OUT_FOUND_BIT] |-> m_axis_tdata[OUT_COUNT_LSB +: 32] == 32'd0 && m_axis_tdata[OUT_MEAN_LSB +: 24] == 24'd0 && m_axis_tdata[OUT_SD_LSB +: 24] == 24'd0 && m_axis_tdata[OUT_MEDIAN_LSB +: 16] == 16'd0, "median missing on a nonempty range")

    // stalled result holds
    `RHS_ASSERT_RST(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // quiet during reset
    `RHS_ASSERT_ANY(a_reset_quiet, clk, !rst_n |-> !m_axis_tvalid && !s_axis_tready, "handshake active during reset")

endmodule

bind rgba_histogram_statistics rgbahs_checker u_rgbahs_checker (.*);

@@ test/tb.sv @@
// Self-checking testbench for the RGBA histogram block with range statistics.
`timescale 1ns / 100ps

module tb;
    import rgbahs_pkg::*;

    localparam int NBINS = 65536;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // One input transfer, unpacked.
    typedef struct {
        logic [OP_W-1:0]     op;
        logic [SAMPLE_W-1:0] blue;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] alpha;
        logic [CH_W-1:0]     ch;
        logic [15:0]         first;
        logic [15:0]         last;
    } pixel_cmd_t;

    // One query answer, split into fields.
    typedef struct packed {
        logic        status;
        logic [31:0] count;
        logic [23:0] mean;
        logic [15:0] median;
        logic        found;
        logic [23:0] sdev;
        logic [31:0] peak;
        logic [31:0] total;
    } stats_t;

    // How a directed row's answer is known: from the predictor, or typed in.
    typedef enum logic [1:0] {ANS_PREDICT, ANS_EMPTY, ANS_INVALID} answer_kind_e;

    typedef struct {
        pixel_cmd_t   cmd;
        answer_kind_e kind;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b1;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic cfg_wr_en = 1'b0;
    logic cfg_wr_data = 1'b0;

    rgba_histogram_statistics dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #1 clk = ~clk;

    // Shadow copy of the histogram store, indexed by channel code.
    bit [31:0] shadow_bins [NUM_CH][NBINS];
    bit [31:0] shadow_pixels;
    bit        shadow_wide;

    stats_t pending_stats[$];
    int     fail_count;
    bit     quiet;          // no idling on either side near the end

    function automatic void bump_bin(int ch, int idx);
        if (shadow_bins[ch][idx] != 32'hFFFF_FFFF)
            shadow_bins[ch][idx]++;
    endfunction

    function automatic void clear_shadow();
        foreach (shadow_bins[c, i])
            shadow_bins[c][i] = '0;
        shadow_pixels = '0;
    endfunction

    // Answer for one query against the shadow store.
    function automatic stats_t range_stats(logic [CH_W-1:0] ch, int first, int last);
        stats_t      o;
        int          nbins;
        int          i;
        bit [63:0]   c, s, run, mean, q, r, t, tt, x, root, bitv, peak;
        bit [127:0]  acc, quo;
        o     = '0;
        nbins = shadow_wide ? NBINS : 256;
        if (ch > CH_ALPHA || first > last || last > nbins - 1)
        begin
            o.status = 1'b1;
            return o;
        end
        c = 0; s = 0; run = 0; mean = 0; acc = 0; root = 0; peak = 0;
        for (i = first; i <= last; i++)
        begin
            c += shadow_bins[ch][i];
            s += 64'(i) * shadow_bins[ch][i];
        end
        for (i = first; i <= last; i++)
        begin
            run += shadow_bins[ch][i];
            if (2 * run > c)
            begin
                o.median = 16'(i);
                o.found  = 1'b1;
                break;
            end
        end
        if (c != 0)
        begin
            q    = s / c;
            r    = s % c;
            mean = (q << 8) + ((r << 8) / c);
            for (i = first; i <= last; i++)
            begin
                t   = (64'(i) << 8);
                t   = (t >= mean) ? t - mean : mean - t;
                tt  = t * t;
                acc += {64'b0, tt} * {96'b0, shadow_bins[ch][i]};
            end
            quo  = acc / {64'b0, c};
            x    = quo[63:0];
            // bitwise integer square root
            bitv = 64'd1 << 62;
            while (bitv > x)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (x >= root + bitv)
                begin
                    x    -= root + bitv;
                    root = (root >> 1) + bitv;
                end
                else
                    root >>= 1;
                bitv >>= 2;
            end
        end
        for (i = 0; i < nbins; i++)
            if (shadow_bins[ch][i] > peak)
                peak = shadow_bins[ch][i];
        o.count = (c > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
        o.mean  = mean[23:0];
        o.sdev  = root[23:0];
        o.peak  = peak[31:0];
        o.total = shadow_pixels;
        return o;
    endfunction

    // Apply one accepted transfer to the shadow store; queue any answer.
    function automatic void track_transfer(pixel_cmd_t cmd, answer_kind_e kind);
        int     mask, b, g, r, a, mx;
        stats_t want;
        mask = shadow_wide ? NBINS - 1 : 255;
        case (cmd.op)
            OP_PIXEL:
            begin
                b  = cmd.blue & mask;
                g  = cmd.green & mask;
                r  = cmd.red & mask;
                a  = cmd.alpha & mask;
                mx = (b > g) ? b : g;
                if (r > mx)
                    mx = r;
                bump_bin(CH_BLUE, b);
                bump_bin(CH_GREEN, g);
                bump_bin(CH_RED, r);
                bump_bin(CH_ALPHA, a);
                bump_bin(CH_VALUE, mx);
                if (shadow_pixels != 32'hFFFF_FFFF)
                    shadow_pixels++;
            end
            OP_CLEAR:
                clear_shadow();
            OP_QUERY:
            begin
                want = '0;
                if (kind == ANS_INVALID)
                    want.status = 1'b1;
                else if (kind == ANS_PREDICT)
                    want = range_stats(cmd.ch, cmd.first, cmd.last);
                pending_stats.push_back(want);
            end
            default:
                ;   // unused op, dropped by the block
        endcase
    endfunction

    // Send one transfer; idle bursts in front unless quiet.
    task automatic send_cmd(pixel_cmd_t cmd, answer_kind_e kind);
        int                    gap;
        logic [IN_TDATA_W-1:0] tdata_v;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tdata_v = '0;
        tdata_v[IN_BLUE_LSB  +: SAMPLE_W] = cmd.blue;
        tdata_v[IN_GREEN_LSB +: SAMPLE_W] = cmd.green;
        tdata_v[IN_RED_LSB   +: SAMPLE_W] = cmd.red;
        tdata_v[IN_ALPHA_LSB +: SAMPLE_W] = cmd.alpha;
        tdata_v[IN_CH_LSB    +: CH_W]     = cmd.ch;
        tdata_v[IN_FIRST_LSB +: 16]       = cmd.first;
        tdata_v[IN_LAST_LSB  +: 16]       = cmd.last;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd.op;
        s_axis_tdata  <= tdata_v;
        do
            @(posedge clk);
        while (!s_axis_tready);
        track_transfer(cmd, kind);
    endtask

    // Hold the input until all answers are back and the block is ready again.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_stats.size() != 0)
            @(posedge clk);
        // pixel and clear transfers leave no answer; give the pipe time to settle
        repeat (20) @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic set_wide(bit wide);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= wide;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_wide = wide;
    endtask

    function automatic pixel_cmd_t random_cmd(bit wide_query_ok);
        pixel_cmd_t cmd;
        int         pick;
        cmd.blue  = 16'($urandom);
        cmd.green = 16'($urandom);
        cmd.red   = 16'($urandom);
        cmd.alpha = 16'($urandom);
        cmd.ch    = CH_W'($urandom_range(0, 4));
        cmd.first = 16'($urandom_range(0, 255));
        cmd.last  = 16'($urandom_range(cmd.first, 255));
        pick = $urandom_range(0, 99);
        if (pick < 72)
        begin
            cmd.op = OP_PIXEL;
            // cluster some pixels so medians and peaks move around
            if ($urandom_range(0, 2) == 0)
                cmd.red = 16'($urandom_range(100, 110));
        end
        else if (pick < 97)
        begin
            cmd.op = OP_QUERY;
            case ($urandom_range(0, 9))
                0: cmd.ch = CH_W'($urandom_range(5, 7));
                1: cmd.first = 16'(cmd.last + 1 + $urandom_range(0, 100));
                2:
                begin
                    cmd.first = 16'($urandom);
                    cmd.last  = 16'($urandom);
                end
                3: cmd.first = 0;
                default: ;
            endcase
            if (!wide_query_ok && cmd.last > 255 && cmd.first <= cmd.last && cmd.ch <= CH_ALPHA)
                cmd.last = 255;
        end
        else
            cmd.op = OP_UNUSED;
        return cmd;
    endfunction

    // Compare one field of an answer.
    function automatic void check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Output side: random ready bursts, answer check on each transfer.
    int     ready_left;
    stats_t got, want;
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status = m_axis_tuser[0];
            got.count  = m_axis_tdata[OUT_COUNT_LSB  +: 32];
            got.mean   = m_axis_tdata[OUT_MEAN_LSB   +: FX_W];
            got.median = m_axis_tdata[OUT_MEDIAN_LSB +: 16];
            got.found  = m_axis_tdata[OUT_FOUND_BIT];
            got.sdev   = m_axis_tdata[OUT_SD_LSB     +: FX_W];
            got.peak   = m_axis_tdata[OUT_PEAK_LSB   +: 32];
            got.total  = m_axis_tdata[OUT_TOTAL_LSB  +: 32];
            if (pending_stats.size() == 0)
            begin
                $display("%0t ns: unexpected answer, expected none, got %0h", $time, got);
                fail_count++;
            end
            else
            begin
                want = pending_stats.pop_front();
                check_field("status", want.status, got.status);
                check_field("range_count", want.count, got.count);
                check_field("mean_fx", want.mean, got.mean);
                check_field("median_bin", want.median, got.median);
                check_field("median_found", want.found, got.found);
                check_field("stddev_fx", want.sdev, got.sdev);
                check_field("peak_count", want.peak, got.peak);
                check_field("pixel_total", want.total, got.total);
            end
        end
        if (quiet)
            m_axis_tready <= 1'b1;
        else if (ready_left > 0)
            ready_left <= ready_left - 1;
        else
        begin
            ready_left    <= $urandom_range(1, 15);
            m_axis_tready <= 1'($urandom_range(0, 1));
        end
    end

    directed_row_t directed [] = '{
        // empty store right after reset
        '{'{OP_QUERY, 16'h0, 16'h0, 16'h0, 16'h0, CH_VALUE, 16'd0, 16'd255}, ANS_EMPTY},
        // bad channel codes, reversed and oversized ranges
        '{'{OP_QUERY, 16'h0, 16'h0, 16'h0, 16'h0, 3'd5, 16'd0, 16'd10}, ANS_INVALID},
        '{'{OP_QUERY, 16'h0, 16'h0, 16'h0, 16'h0, 3'd7, 16'd0, 16'd0}, ANS_INVALID},
        '{'{OP_QUERY, 16'h0, 16'h0, 16'h0, 16'h0, CH_RED, 16'd10, 16'd5}, ANS_INVALID},
        '{'{OP_QUERY, 16'h0, 16'h0, 16'h0, 16'h0, CH_GREEN, 16'd0, 16'd256}, ANS_INVALID},
        '{'{OP_QUERY, 16'h0, 16'h0, 16'h0, 16'h0, CH_ALPHA, 16'd0, 16'hFFFF}, ANS_INVALID},
        // sample extremes; narrow mode keeps the low byte only
        '{'{OP_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd0, 16'd0, 16'd0}, ANS_PREDICT},
        '{'{OP_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'd0, 16'd0, 16'd0}, ANS_PREDICT},
        '{'{OP_PIXEL, 16'h0012, 16'h00AB, 16'h1234, 16'h00FF, 3'd0, 16'd0, 16'd0}, ANS_PREDICT},
        '{'{OP_PIXEL, 16'hA55A, 16'h5AA5, 16'h0080, 16'h0001, 3'd0, 16'd0, 16'd0}, ANS_PREDICT},
        // unused op gives nothing
        '{'{OP_UNUSED, 16'h1111, 16'h2222, 16'h3333, 16'h4444, CH_RED, 16'd0, 16'd255},
          ANS_PREDICT},
        '{'{OP_QUERY, 16'h0, 16'h0, 16'h0, 16'h0, CH_VALUE, 16'd0, 16'd255}, ANS_PREDICT},
        '{'{OP_QUERY, 16'h0, 16'h0, 16'h0, 16'h0, CH_RED, 16'd0, 16'd255}, ANS_PREDICT},
        '{'{OP_QUERY, 16'h0, 16'h0, 16'h0, 16'h0, CH_GREEN, 16'd0, 16'd255}, ANS_PREDICT},
        '{'{OP_QUERY, 16'h0, 16'h0, 16'h0, 16'h0, CH_BLUE, 16'd0, 16'd255}, ANS_PREDICT},
        '{'{OP_QUERY, 16'h0, 16'h0, 16'h0, 16'h0, CH_ALPHA, 16'd0, 16'd255}, ANS_PREDICT},
        '{'{OP_QUERY, 16'h0, 16'h0, 16'h0, 16'h0, CH_RED, 16'd255, 16'd255}, ANS_PREDICT},
        '{'{OP_QUERY, 16'h0, 16'h0, 16'h0, 16'h0, CH_BLUE, 16'd0, 16'd0}, ANS_PREDICT},
        // empty sub-range with pixels elsewhere
        '{'{OP_QUERY, 16'h0, 16'h0, 16'h0, 16'h0, CH_GREEN, 16'd200, 16'd250}, ANS_PREDICT},
        '{'{OP_CLEAR, 16'h0, 16'h0, 16'h0, 16'h0, 3'd0, 16'd0, 16'd0}, ANS_PREDICT},
        '{'{OP_QUERY, 16'h0, 16'h0, 16'h0, 16'h0, CH_VALUE, 16'd0, 16'd255}, ANS_EMPTY},
        '{'{OP_PIXEL, 16'h0007, 16'h0009, 16'h0003, 16'h00C0, 3'd0, 16'd0, 16'd0}, ANS_PREDICT},
        '{'{OP_QUERY, 16'h0, 16'h0, 16'h0, 16'h0, CH_ALPHA, 16'd0, 16'd255}, ANS_PREDICT}
    };

    initial
    begin
        pixel_cmd_t cmd;
        int         n;
        rst_n       <= 1'b0;
        fail_count  = 0;
        quiet       = 1'b0;
        ready_left  = 0;
        shadow_wide = 1'b0;
        clear_shadow();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        set_wide(1'b0);
        foreach (directed[k])
            send_cmd(directed[k].cmd, directed[k].kind);

        // narrow mode, random content
        for (n = 0; n < 380; n++)
        begin
            if (n == 200)
                drain();    // sender waits out every answer once
            if (n == 250)
            begin
                cmd    = random_cmd(1'b0);
                cmd.op = OP_CLEAR;
                send_cmd(cmd, ANS_PREDICT);
            end
            send_cmd(random_cmd(1'b0), ANS_PREDICT);
        end

        // wide mode: full 16-bit samples, only a few costly queries
        set_wide(1'b1);
        for (n = 0; n < 60; n++)
        begin
            cmd = random_cmd(1'b0);
            cmd.op = OP_PIXEL;
            send_cmd(cmd, ANS_PREDICT);
        end
        cmd = random_cmd(1'b1);
        cmd.op = OP_QUERY;
        cmd.ch = CH_VALUE; cmd.first = 16'd0; cmd.last = 16'hFFFF;
        send_cmd(cmd, ANS_PREDICT);
        cmd.ch = CH_BLUE; cmd.first = 16'h8000; cmd.last = 16'hFFFF;
        send_cmd(cmd, ANS_PREDICT);
        cmd.ch = CH_ALPHA; cmd.first = 16'h7FFF; cmd.last = 16'h0100;
        send_cmd(cmd, ANS_INVALID);
        cmd.ch = CH_RED; cmd.first = 16'd0; cmd.last = 16'h7FFF;
        send_cmd(cmd, ANS_PREDICT);

        // back to narrow: counts in bins 0..255 survive the mode change
        set_wide(1'b0);
        for (n = 0; n < 420; n++)
        begin
            if (n == 120)
            begin
                cmd    = random_cmd(1'b0);
                cmd.op = OP_CLEAR;
                send_cmd(cmd, ANS_PREDICT);
            end
            if (n == 270)
                quiet = 1'b1;
            send_cmd(random_cmd(1'b0), ANS_PREDICT);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/rgbahs_pkg.sv
hw/rtl/rgba_histogram_statistics.sv
hw/rtl/rgbahs_checker.sv
test/tb.sv
